[sv/csv_field_tokenizer_assert.svh]
// Assertion shorthands for the tokenizer checker.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define CSVFT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csv tokenizer assertion failed");

// Checked on every rising edge, reset included.
`define CSVFT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("csv tokenizer assertion failed during reset");

`endif

[sv/csvft_pkg.sv]
package csvft_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_value;
    logic       field_done;
    logic       record_done;
  } tok_res_t;

endpackage

[sv/csv_field_tokenizer.sv]
// CSV field tokenizer.
// Input channel: one item per handshake (in_valid_i high, in_stall_o low),
// either a text byte (opcode_i = data) or an end-of-input marker that closes
// any open field. Output channel: exactly one result per input item, in
// order, carrying an optional decoded content byte plus field_done and
// record_done flags for the field that closed before that byte.
// An accepted item is held in the input register, is then decoded into the
// result register, which drives the output, and can be taken from there.
// Throughput is one item per cycle while out_stall_i is low; the parser
// state update is a single short decode of the registered byte against the
// current state.
// A carriage return is held in the parser state, so the field end it causes
// is reported on the following item.
// Reset empties both registers and returns the parser to line start.
// When the receiver stalls, the result register holds its item; the input
// register still fills once, then in_stall_o rises until the output drains.
module csv_field_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [7:0] char_value_o,
  output logic       field_done_o,
  output logic       record_done_o
);
  import csvft_pkg::*;

  typedef enum logic [2:0] {
    ST_LINE   = 3'd0,
    ST_FIELD  = 3'd1,
    ST_PLAIN  = 3'd2,
    ST_QUOTED = 3'd3,
    ST_QSEEN  = 3'd4,
    ST_CR     = 3'd5
  } state_e;

  state_e     state_q, state_d;
  logic       in_valid_q;
  logic       opcode_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  tok_res_t   res_q, res_d;
  tok_res_t   bf_res;
  state_e     bf_state;
  logic       advance;
  logic       in_accept;

  assign advance   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  // Byte arriving where a new field begins.
  always_comb begin
    bf_res   = '0;
    bf_state = ST_PLAIN;
    priority if (byte_q == CH_QUOTE) begin
      bf_state = ST_QUOTED;
    end else if (byte_q == CH_COMMA) begin
      bf_res.field_done = 1'b1;
      bf_state          = ST_FIELD;
    end else if (byte_q == CH_LF) begin
      bf_res.field_done  = 1'b1;
      bf_res.record_done = 1'b1;
      bf_state           = ST_LINE;
    end else if (byte_q == CH_CR) begin
      bf_state = ST_CR;
    end else begin
      bf_res.char_valid = 1'b1;
      bf_res.char_value = byte_q;
    end
  end

  always_comb begin
    res_d   = '0;
    state_d = ST_LINE;
    if (opcode_q == OP_FLUSH) begin
      if (state_q != ST_LINE) begin
        res_d.field_done  = 1'b1;
        res_d.record_done = 1'b1;
      end
    end else begin
      unique case (state_q)
        ST_PLAIN: begin
          priority if (byte_q == CH_COMMA) begin
            res_d.field_done = 1'b1;
            state_d          = ST_FIELD;
          end else if (byte_q == CH_LF) begin
            res_d.field_done  = 1'b1;
            res_d.record_done = 1'b1;
          end else if (byte_q == CH_CR) begin
            state_d = ST_CR;
          end else begin
            res_d.char_valid = 1'b1;
            res_d.char_value = byte_q;
            state_d          = ST_PLAIN;
          end
        end
        ST_QUOTED: begin
          if (byte_q == CH_QUOTE) begin
            state_d = ST_QSEEN;
          end else begin
            res_d.char_valid = 1'b1;
            res_d.char_value = byte_q;
            state_d          = ST_QUOTED;
          end
        end
        ST_QSEEN: begin
          priority if (byte_q == CH_QUOTE) begin
            res_d.char_valid = 1'b1;
            res_d.char_value = CH_QUOTE;
            state_d          = ST_QUOTED;
          end else if (byte_q == CH_COMMA) begin
            res_d.field_done = 1'b1;
            state_d          = ST_FIELD;
          end else if (byte_q == CH_LF) begin
            res_d.field_done  = 1'b1;
            res_d.record_done = 1'b1;
          end else if (byte_q == CH_CR) begin
            state_d = ST_CR;
          end else begin
            // stray text after a closing quote starts a new record
            res_d.char_valid  = 1'b1;
            res_d.char_value  = byte_q;
            res_d.field_done  = 1'b1;
            res_d.record_done = 1'b1;
            state_d           = ST_PLAIN;
          end
        end
        ST_CR: begin
          priority if (byte_q == CH_LF) begin
            res_d.field_done  = 1'b1;
            res_d.record_done = 1'b1;
          end else if (byte_q == CH_COMMA) begin
            res_d.field_done = 1'b1;
            state_d          = ST_FIELD;
          end else begin
            // lone carriage return: close the record, restart on this byte
            res_d.char_valid  = bf_res.char_valid;
            res_d.char_value  = bf_res.char_value;
            res_d.field_done  = 1'b1;
            res_d.record_done = 1'b1;
            state_d           = bf_state;
          end
        end
        default: begin
          res_d   = bf_res;
          state_d = bf_state;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LINE;
      in_valid_q  <= 1'b0;
      opcode_q    <= OP_DATA;
      byte_q      <= 8'h00;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (in_accept) begin
        opcode_q <= opcode_i;
        byte_q   <= data_byte_i;
      end
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q     <= state_d;
        res_q       <= res_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_valid_o  = res_q.char_valid;
  assign char_value_o  = res_q.char_value;
  assign field_done_o  = res_q.field_done;
  assign record_done_o = res_q.record_done;

endmodule

[sv/csvft_checker.sv]
`include "csv_field_tokenizer_assert.svh"

module csvft_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       char_valid_o,
  input logic [7:0] char_value_o,
  input logic       field_done_o,
  input logic       record_done_o
);

  `CSVFT_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

  `CSVFT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable({char_valid_o, char_value_o, field_done_o, record_done_o}))

  // an empty output side always lets the input register drain
  `CSVFT_ASSERT(a_no_idle_stall, clk_i, rst_ni, !out_valid_o |-> !in_stall_o)

  `CSVFT_ASSERT(a_char_zero, clk_i, rst_ni, out_valid_o && !char_valid_o |-> char_value_o == 8'h00)

  `CSVFT_ASSERT(a_record_has_field, clk_i, rst_ni, out_valid_o && record_done_o |-> field_done_o)

endmodule

bind csv_field_tokenizer csvft_checker u_csvft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .char_valid_o  (char_valid_o),
  .char_value_o  (char_value_o),
  .field_done_o  (field_done_o),
  .record_done_o (record_done_o)
);
